// ===== rtl/pva_pkg.sv =====
// shared types and constants for the polyphonic voice allocator
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

	localparam int MAX_VOICES = 16;
	localparam int VIDX_W     = 4;
	localparam int CNT_W      = $clog2(MAX_VOICES + 1);
	localparam int AV_W       = 5;
	localparam int ADDR_W     = 3;
	localparam int STAMP_W    = 32;
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 16;
	localparam int HELD_W     = 8;

	localparam logic [VEL_W-1:0]  VEL_FULL     = 16'd32768;
	localparam logic [AV_W-1:0]   AV_RESET     = 5'd8;
	localparam logic [HELD_W-1:0] HELD_MAX     = 8'd255;
	localparam logic [ADDR_W-1:0] ADDR_ACTIVE  = 3'd0;

	typedef enum logic [1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_ALL_OFF  = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [NOTE_W-1:0] note_number;
		logic [VEL_W-1:0]  note_velocity;
	} event_item_t;

	typedef struct packed {
		logic [VIDX_W-1:0] voice_index;
		logic              voice_valid;
		logic              any_gate;
		logic [HELD_W-1:0] held_count;
		logic [NOTE_W-1:0] recent_note;
		logic [VEL_W-1:0]  recent_velocity;
	} result_item_t;

	typedef struct packed {
		logic [NOTE_W-1:0]  note;
		logic [VEL_W-1:0]   velocity;
		logic [STAMP_W-1:0] stamp;
	} voice_rec_t;

endpackage

`default_nettype wire

// ===== rtl/pva_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module pva_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                  wdata,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic      [W-1:0]                  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/poly_voice_allocator.sv =====
// polyphonic voice allocator: note events in, voice assignments out
//
//  channel   direction  handshake                      payload
//  event     in         event_valid / event_ready      event_item_t
//  result    out        result_valid / result_ready    result_item_t
//  config    in         apb psel/penable/pwrite        active_voices at 0x0
//
// note on with a never-used voice, all-off and unused codes go from idle straight to finish
// note on with a full pool and note off first scan the voice ram in the scan state
// the scan reads one voice record per cycle through the single ram read port
// reset clears used/gate flags, stamp clock, counters; active_voices resets to 8
// a stalled result holds in the output register while the next item is accepted
`timescale 1ns / 1ps
`default_nettype none

module poly_voice_allocator
	import pva_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         event_valid,
	output logic              event_ready,
	input  wire event_item_t  event_item,
	output logic              result_valid,
	input  wire logic         result_ready,
	output result_item_t      result_item,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [AV_W-1:0]       av_q;
	logic [MAX_VOICES-1:0] used_q;
	logic [MAX_VOICES-1:0] gate_q;
	logic [STAMP_W-1:0]    clock_q;
	logic [HELD_W-1:0]     held_q;
	logic                  ggate_q;
	logic [NOTE_W-1:0]     last_note_q;
	logic [VEL_W-1:0]      last_vel_q;

	opcode_t               op_q;
	logic [NOTE_W-1:0]     note_q;
	logic [VEL_W-1:0]      vel_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rd_vld_s1;
	logic [VIDX_W-1:0]     idx_s1;
	logic                  a_found_q;
	logic [VIDX_W-1:0]     a_idx_q;
	logic [STAMP_W-1:0]    a_stamp_q;
	logic                  b_found_q;
	logic [VIDX_W-1:0]     b_idx_q;
	logic [STAMP_W-1:0]    b_stamp_q;
	logic                  chosen_q;
	logic [VIDX_W-1:0]     chosen_idx_q;

	logic                  out_valid_q;
	result_item_t          out_q;

	logic [CNT_W-1:0]      pool_n;
	logic                  free_found;
	logic [VIDX_W-1:0]     free_idx;
	logic [VEL_W-1:0]      vel_sat;
	logic                  cfg_wr;
	logic                  accept;
	logic                  issue;
	logic                  out_free;
	logic                  ram_we;
	voice_rec_t            ram_wdata;
	voice_rec_t            ram_rdata;
	logic                  a_hit;
	logic                  b_hit;
	logic [HELD_W-1:0]     held_next;
	logic                  ggate_next;
	logic                  ev_on;
	logic                  ev_off;
	logic                  take_free;
	logic                  start_scan;

	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite && (paddr == ADDR_ACTIVE);
	assign prdata       = (paddr == ADDR_ACTIVE) ? {27'd0, av_q} : 32'd0;
	assign event_ready  = (state_q == ST_IDLE);
	assign accept       = event_valid && event_ready;
	assign result_valid = out_valid_q;
	assign result_item  = out_q;
	assign out_free     = !out_valid_q || result_ready;

	assign pool_n = (av_q > AV_W'(MAX_VOICES)) ? CNT_W'(MAX_VOICES) : CNT_W'(av_q);

	assign vel_sat = (event_item.note_velocity == '0 || event_item.note_velocity > VEL_FULL)
		? VEL_FULL : event_item.note_velocity;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int v = MAX_VOICES - 1; v >= 0; v--) begin
			if (!used_q[v] && (CNT_W'(v) < pool_n)) begin
				free_found = 1'b1;
				free_idx   = VIDX_W'(v);
			end
		end
	end

	assign ev_on      = (opcode_t'(event_item.opcode) == OP_NOTE_ON);
	assign ev_off     = (opcode_t'(event_item.opcode) == OP_NOTE_OFF);
	assign take_free  = ev_on && (pool_n != '0) && free_found;
	assign start_scan = (pool_n != '0) && ((ev_on && !free_found) || ev_off);

	assign issue = (state_q == ST_SCAN) && (cnt_q < pool_n);

	// free gate-off voice for note on, gated note match for note off
	always_comb begin
		if (op_q == OP_NOTE_ON) begin
			a_hit = !gate_q[idx_s1];
		end else begin
			a_hit = gate_q[idx_s1] && (ram_rdata.note == note_q);
		end
		a_hit = a_hit && (!a_found_q || ram_rdata.stamp < a_stamp_q);
		b_hit = !b_found_q || ram_rdata.stamp < b_stamp_q;
	end

	assign ram_we = (state_q == ST_FINISH) && out_free && (op_q == OP_NOTE_ON) && chosen_q;
	assign ram_wdata = '{note: note_q, velocity: vel_q, stamp: clock_q + 1'b1};

	always_comb begin
		held_next  = held_q;
		ggate_next = ggate_q;
		unique case (op_q)
			OP_NOTE_ON: begin
				held_next  = (held_q < HELD_MAX) ? held_q + 1'b1 : held_q;
				ggate_next = 1'b1;
			end
			OP_NOTE_OFF: begin
				held_next  = (held_q != '0) ? held_q - 1'b1 : held_q;
				ggate_next = (held_next != '0);
			end
			OP_ALL_OFF: begin
				held_next  = '0;
				ggate_next = 1'b0;
			end
			OP_NONE: begin
				held_next  = held_q;
				ggate_next = ggate_q;
			end
			default: begin
				held_next  = held_q;
				ggate_next = ggate_q;
			end
		endcase
	end

	pva_ram #(
		.W($bits(voice_rec_t)),
		.D(MAX_VOICES)
	) u_voice_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(chosen_idx_q),
		.wdata(ram_wdata),
		.raddr(cnt_q[VIDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			av_q        <= AV_RESET;
			used_q      <= '0;
			gate_q      <= '0;
			clock_q     <= '0;
			held_q      <= '0;
			ggate_q     <= 1'b0;
			last_note_q <= '0;
			last_vel_q  <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			op_q        <= OP_NONE;
			cnt_q       <= '0;
			a_found_q   <= 1'b0;
			b_found_q   <= 1'b0;
			chosen_q    <= 1'b0;
		end else begin
			if (out_valid_q && result_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				av_q    <= pwdata[AV_W-1:0];
				used_q  <= '0;
				gate_q  <= '0;
				clock_q <= '0;
			end
			rd_vld_s1 <= issue;
			idx_s1    <= cnt_q[VIDX_W-1:0];
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q      <= opcode_t'(event_item.opcode);
						note_q    <= event_item.note_number;
						vel_q     <= vel_sat;
						cnt_q     <= '0;
						a_found_q <= 1'b0;
						b_found_q <= 1'b0;
						if (start_scan) begin
							state_q      <= ST_SCAN;
							chosen_q     <= 1'b0;
							chosen_idx_q <= '0;
						end else begin
							state_q      <= ST_FINISH;
							chosen_q     <= take_free;
							chosen_idx_q <= take_free ? free_idx : '0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_vld_s1) begin
						if (a_hit) begin
							a_found_q <= 1'b1;
							a_idx_q   <= idx_s1;
							a_stamp_q <= ram_rdata.stamp;
						end
						if (b_hit) begin
							b_found_q <= 1'b1;
							b_idx_q   <= idx_s1;
							b_stamp_q <= ram_rdata.stamp;
						end
					end else if (!issue) begin
						state_q <= ST_FINISH;
						if (op_q == OP_NOTE_ON) begin
							chosen_q     <= 1'b1;
							chosen_idx_q <= a_found_q ? a_idx_q : b_idx_q;
						end else begin
							chosen_q     <= a_found_q;
							chosen_idx_q <= a_found_q ? a_idx_q : '0;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						held_q      <= held_next;
						ggate_q     <= ggate_next;
						out_q.voice_index <= chosen_q ? chosen_idx_q : '0;
						out_q.voice_valid <= chosen_q;
						out_q.any_gate    <= ggate_next;
						out_q.held_count  <= held_next;
						out_q.recent_note     <= (op_q == OP_NOTE_ON) ? note_q : last_note_q;
						out_q.recent_velocity <= (op_q == OP_NOTE_ON) ? vel_q : last_vel_q;
						unique case (op_q)
							OP_NOTE_ON: begin
								last_note_q <= note_q;
								last_vel_q  <= vel_q;
								if (chosen_q) begin
									clock_q <= clock_q + 1'b1;
									used_q[chosen_idx_q] <= 1'b1;
									gate_q[chosen_idx_q] <= 1'b1;
								end
							end
							OP_NOTE_OFF: begin
								if (chosen_q) begin
									gate_q[chosen_idx_q] <= 1'b0;
								end
							end
							OP_ALL_OFF: begin
								gate_q <= '0;
							end
							OP_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a gated voice has always been assigned since the last pool clear
	a_gate_used: assert property (@(posedge clk) disable iff (!arst_n)
		(gate_q & ~used_q) == '0)
		else $error("gated voice not marked used");

	a_gate_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.any_gate == (out_q.held_count != '0)))
		else $error("global gate disagrees with held count");

	a_index_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && chosen_q) |-> (CNT_W'(chosen_idx_q) < pool_n))
		else $error("chosen voice outside pool");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("voice read returned outside scan");

	a_write_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !rd_vld_s1 && !issue)
		else $error("voice write overlaps scan");

endmodule

`default_nettype wire

// ===== tb/tb_poly_voice_allocator.sv =====
// testbench for the polyphonic voice allocator: note events against an in-bench voice pool model
`timescale 1ns / 1ps
`default_nettype none

module tb_poly_voice_allocator;
	import pva_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic event_valid = 1'b0;
	logic event_ready;
	event_item_t event_item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_item_t result_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	poly_voice_allocator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_valid  (event_valid),
		.event_ready  (event_ready),
		.event_item   (event_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// voice pool mirror
	logic [AV_W-1:0]    pool_limit = AV_RESET;
	logic               pool_used  [MAX_VOICES];
	logic               pool_gate  [MAX_VOICES];
	logic [NOTE_W-1:0]  pool_note  [MAX_VOICES];
	logic [VEL_W-1:0]   pool_vel   [MAX_VOICES];
	logic [STAMP_W-1:0] pool_stamp [MAX_VOICES];
	logic [STAMP_W-1:0] stamp_count = '0;
	logic [HELD_W-1:0]  held_cnt    = '0;
	logic               gate_any    = 1'b0;
	logic [NOTE_W-1:0]  latest_note = '0;
	logic [VEL_W-1:0]   latest_vel  = '0;

	result_item_t pending_allocations [$];
	logic [NOTE_W-1:0] held_list [$];

	int error_count = 0;
	int checked_count = 0;
	int sent_count = 0;
	int config_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int hold_request = 0;
	int hold_left = 0;
	bit tx_steady = 1'b0;
	bit ev_driving = 1'b0;
	rx_mode_t rx_mode = RX_ALWAYS;
	logic [7:0] rx_pattern = 8'b1011_0110;
	result_item_t want;
	logic bad;

	function automatic void clear_pool();
		for (int v = 0; v < MAX_VOICES; v++) begin
			pool_used[v] = 1'b0;
			pool_gate[v] = 1'b0;
			pool_note[v] = '0;
			pool_vel[v] = '0;
			pool_stamp[v] = '0;
		end
		stamp_count = '0;
	endfunction

	function automatic result_item_t allocate_voice_event(input event_item_t ev);
		result_item_t res;
		logic [VEL_W-1:0] vel;
		int n;
		int chosen;
		n = (pool_limit > MAX_VOICES) ? MAX_VOICES : int'(pool_limit);
		chosen = -1;
		vel = ev.note_velocity;
		case (opcode_t'(ev.opcode))
		OP_NOTE_ON: begin
			if (vel == 0 || vel > VEL_FULL)
				vel = VEL_FULL;
			for (int v = 0; v < n && chosen < 0; v++)
				if (!pool_used[v])
					chosen = v;
			if (chosen < 0)
				for (int v = 0; v < n; v++)
					if (!pool_gate[v] && (chosen < 0 || pool_stamp[v] < pool_stamp[chosen]))
						chosen = v;
			if (chosen < 0)
				for (int v = 0; v < n; v++)
					if (chosen < 0 || pool_stamp[v] < pool_stamp[chosen])
						chosen = v;
			if (chosen >= 0) begin
				stamp_count = stamp_count + 1'b1;
				pool_used[chosen] = 1'b1;
				pool_gate[chosen] = 1'b1;
				pool_note[chosen] = ev.note_number;
				pool_vel[chosen] = vel;
				pool_stamp[chosen] = stamp_count;
			end
			if (held_cnt != HELD_MAX)
				held_cnt = held_cnt + 1'b1;
			latest_note = ev.note_number;
			latest_vel = vel;
			gate_any = 1'b1;
		end
		OP_NOTE_OFF: begin
			for (int v = 0; v < n; v++)
				if (pool_gate[v] && pool_note[v] == ev.note_number &&
						(chosen < 0 || pool_stamp[v] < pool_stamp[chosen]))
					chosen = v;
			if (chosen >= 0)
				pool_gate[chosen] = 1'b0;
			if (held_cnt != 0)
				held_cnt = held_cnt - 1'b1;
			gate_any = (held_cnt != 0);
		end
		OP_ALL_OFF: begin
			for (int v = 0; v < MAX_VOICES; v++)
				pool_gate[v] = 1'b0;
			held_cnt = '0;
			gate_any = 1'b0;
		end
		default: ;
		endcase
		res.voice_index = (chosen >= 0) ? VIDX_W'(chosen) : '0;
		res.voice_valid = (chosen >= 0);
		res.any_gate = gate_any;
		res.held_count = held_cnt;
		res.recent_note = latest_note;
		res.recent_velocity = latest_vel;
		return res;
	endfunction

	function automatic logic [VEL_W-1:0] random_velocity();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return VEL_W'($urandom_range(32768, 65535));
		return VEL_W'($urandom_range(1, 32768));
	endfunction

	function automatic event_item_t make_item(input opcode_t op, input int note,
			input logic [VEL_W-1:0] vel);
		event_item_t ev;
		ev.opcode = op;
		ev.note_number = NOTE_W'(note);
		ev.note_velocity = vel;
		return ev;
	endfunction

	// mostly note on / note off pairs over a narrow range, some noise
	function automatic event_item_t random_event();
		event_item_t ev;
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		if (held_list.size() > 24 && pick < 50)
			pick = 60;
		ev = make_item(OP_NOTE_ON, $urandom_range(48, 59), random_velocity());
		if (pick < 50) begin
			if ($urandom_range(0, 4) == 0)
				ev.note_number = NOTE_W'($urandom_range(0, 127));
			held_list.insert(held_list.size(), ev.note_number);
		end else if (pick < 88) begin
			ev.opcode = OP_NOTE_OFF;
			if (held_list.size() != 0 && pick < 84) begin
				k = $urandom_range(0, held_list.size() - 1);
				ev.note_number = held_list[k];
				held_list.delete(k);
			end
		end else if (pick < 92) begin
			ev.opcode = OP_ALL_OFF;
			held_list.delete();
		end else if (pick < 95) begin
			ev.opcode = OP_NONE;
		end else begin
			ev.opcode = 2'($urandom_range(0, 3));
			ev.note_number = NOTE_W'($urandom_range(0, 127));
			ev.note_velocity = VEL_W'($urandom_range(0, 65535));
		end
		return ev;
	endfunction

	task automatic send_item(input event_item_t ev);
		int gap;
		result_item_t res;
		gap = 0;
		if (!tx_steady) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
				burst_left = $urandom_range(1, 10);
			end
			burst_left--;
		end
		if (gap != 0) begin
			if (ev_driving) begin
				event_valid <= 1'b0;
				ev_driving = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		event_valid <= 1'b1;
		event_item <= ev;
		ev_driving = 1'b1;
		do @(posedge clk); while (!event_ready);
		res = allocate_voice_event(ev);
		pending_allocations.insert(pending_allocations.size(), res);
		sent_count++;
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_item(random_event());
	endtask

	task automatic wait_drained();
		if (ev_driving) begin
			event_valid <= 1'b0;
			ev_driving = 1'b0;
		end
		while (pending_allocations.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_active_voices(input logic [AV_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_ACTIVE;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pool_limit = value;
		clear_pool();
		config_count++;
	endtask

	task automatic test_directed();
		tx_steady = 1'b1;
		rx_mode = RX_ALWAYS;
		send_item(make_item(OP_NOTE_ON, 60, 16'd0));
		send_item(make_item(OP_NOTE_ON, 127, VEL_FULL));
		send_item(make_item(OP_NOTE_ON, 0, 16'd32769));
		send_item(make_item(OP_NOTE_ON, 61, 16'hFFFF));
		send_item(make_item(OP_NOTE_ON, 60, 16'd1));
		send_item(make_item(OP_NOTE_ON, 62, 16'd100));
		send_item(make_item(OP_NOTE_ON, 63, 16'h7FFF));
		send_item(make_item(OP_NOTE_ON, 64, 16'h5555));
		// pool full and all held: steal
		send_item(make_item(OP_NOTE_ON, 65, 16'h2AAA));
		send_item(make_item(OP_NOTE_OFF, 60, 16'h0));
		send_item(make_item(OP_NOTE_OFF, 60, 16'hFFFF));
		send_item(make_item(OP_NOTE_ON, 66, 16'd4096));
		send_item(make_item(OP_NOTE_OFF, 99, 16'd0));
		send_item(make_item(OP_NONE, 127, 16'hFFFF));
		send_item(make_item(OP_ALL_OFF, 0, 16'd0));
		send_item(make_item(OP_NOTE_OFF, 61, 16'd0));
		send_item(make_item(OP_NOTE_ON, 67, 16'd8192));
		send_item(make_item(OP_NOTE_ON, 68, 16'd8192));
		send_item(make_item(OP_NOTE_OFF, 127, 16'd0));
		tx_steady = 1'b0;
	endtask

	task automatic test_pool_sizes();
		logic [AV_W-1:0] sizes [7];
		sizes = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd2, 5'd5};
		sizes[6] = AV_W'($urandom_range(0, 31));
		for (int i = 0; i < 7; i++) begin
			set_active_voices(sizes[i]);
			rx_mode = rx_mode_t'(i % 3);
			send_item(make_item(OP_NOTE_ON, $urandom_range(0, 127), random_velocity()));
			send_random(19);
		end
	endtask

	task automatic test_held_saturation();
		set_active_voices(5'd4);
		rx_mode = RX_RANDOM;
		for (int i = 0; i < 270; i++)
			send_item(make_item(OP_NOTE_ON, $urandom_range(0, 127), random_velocity()));
		for (int i = 0; i < 5; i++)
			send_item(make_item(OP_NOTE_OFF, $urandom_range(0, 127), random_velocity()));
		send_item(make_item(OP_ALL_OFF, $urandom_range(0, 127), random_velocity()));
		held_list.delete();
	endtask

	task automatic test_backpressure();
		set_active_voices(5'd8);
		rx_mode = RX_PATTERN;
		tx_steady = 1'b1;
		hold_request = 300;
		send_random(40);
		tx_steady = 1'b0;
		wait_drained();
		send_random(10);
	endtask

	task automatic test_random();
		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
			0: set_active_voices(5'd8);
			1: set_active_voices(5'd16);
			2: set_active_voices(5'd3);
			default: set_active_voices(AV_W'($urandom_range(0, 31)));
			endcase
			rx_mode = rx_mode_t'(seg % 3);
			tx_steady = (seg == 3);
			send_random(60);
		end
		tx_steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			case (rx_mode)
			RX_ALWAYS: result_ready <= 1'b1;
			RX_RANDOM: result_ready <= ($urandom_range(0, 99) < 60);
			default: begin
				result_ready <= rx_pattern[0];
				rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
			end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_allocations.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: idx=%0d vld=%0d", result_item.voice_index,
						result_item.voice_valid);
			end else begin
				want = pending_allocations.pop_front();
				checked_count++;
				bad = (result_item.voice_index !== want.voice_index) ||
					(result_item.voice_valid !== want.voice_valid) ||
					(result_item.any_gate !== want.any_gate) ||
					(result_item.held_count !== want.held_count) ||
					(result_item.recent_note !== want.recent_note) ||
					(result_item.recent_velocity !== want.recent_velocity);
				if (bad) begin
					error_count++;
					if (error_count <= 10) begin
						$display("mismatch: exp idx=%0d vld=%0d gate=%0d held=%0d note=%0d vel=%0d",
							want.voice_index, want.voice_valid, want.any_gate, want.held_count,
							want.recent_note, want.recent_velocity);
						$display("          got idx=%0d vld=%0d gate=%0d held=%0d note=%0d vel=%0d",
							result_item.voice_index, result_item.voice_valid,
							result_item.any_gate, result_item.held_count,
							result_item.recent_note, result_item.recent_velocity);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_allocations.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clear_pool();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pool_sizes();
		test_held_saturation();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		error_count += pending_allocations.size();
		$display("covered %0d note events, %0d results checked, %0d pool size writes",
			sent_count, checked_count, config_count);
		$display("incl. empty/oversized pools, stealing, held count limits, velocity clamp, stalls");
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/pva_pkg.sv
rtl/pva_ram.sv
rtl/poly_voice_allocator.sv
tb/tb_poly_voice_allocator.sv
